@@ hdl/mbm_pkg.sv @@
package mbm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SOLVE = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_ADJ_CLR,
    OP_EDGE_RD,
    OP_EDGE_WR,
    OP_PART_CLR,
    OP_SOLVE_INIT,
    OP_ROOT_START,
    OP_SCAN_STEP,
    OP_FOUND,
    OP_VIS_RD,
    OP_PUSH,
    OP_POP_RD,
    OP_POP_LOAD,
    OP_AUG_TOP,
    OP_AUG_RD,
    OP_AUG_WR,
    OP_ROOT_NEXT,
    OP_REPORT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  typedef struct packed {
    cmd_t item_cmd;
    logic edge_ok;
    logic sweep_last;
    logic lt_zero;
    logic root_last;
    logic next_end;
    logic row_bit;
    logic unmatched;
    logic push_block;
    logic sp_one;
  } dp_stat_t;

  localparam int unsigned MATCH_SAT = 127;

endpackage

@@ hdl/mbm_ram.sv @@
module mbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/mbm_datapath.sv @@
module mbm_datapath
  import mbm_pkg::*;
#(
  parameter int NODES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_ctl_t    ctl,
  output dp_stat_t   stat,
  input  logic [1:0] cmd,
  input  logic [5:0] left_index,
  input  logic [5:0] right_index,
  input  logic [6:0] left_total,
  input  logic [7:0] node_total,
  output logic       done,
  output logic [6:0] matching_size,
  output logic [7:0] independent_size,
  output logic       solved
);

  localparam int IW = $clog2(NODES);
  localparam int CW = IW + 1;
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int EW = (CW > 6) ? CW : 6;
  localparam int MW = (CW > 8) ? CW : 8;

  cmd_t          cmd_q;
  logic          edge_ok;
  logic [IW-1:0] li_q;
  logic [IW-1:0] ri_q;
  logic [CW-1:0] lt_q;
  logic [7:0]    nt_q;
  logic [IW-1:0] sweep;
  logic [IW-1:0] root;
  logic [IW-1:0] top_lv;
  logic [IW-1:0] top_cur;
  logic [CW-1:0] top_next;
  logic [CW-1:0] sp;
  logic [CW-1:0] count;

  logic [LW-1:0] lt_wide;
  logic [LW-1:0] lt_eff;
  logic [EW-1:0] li_wide;
  logic [EW-1:0] ri_wide;
  logic [CW-1:0] epoch;
  logic [CW-1:0] sp_m1;
  logic [CW-1:0] sp_m2;
  logic [MW-1:0] cnt_wide;
  logic [MW-1:0] nt_wide;
  logic [MW-1:0] ind_diff;

  logic             adj_we, adj_re;
  logic [IW-1:0]    adj_waddr, adj_raddr;
  logic [NODES-1:0] adj_wdata, adj_rdata;
  logic             part_we, part_re;
  logic [IW-1:0]    part_waddr, part_raddr;
  logic [CW-1:0]    part_wdata, part_rdata;
  logic             vis_we, vis_re;
  logic [IW-1:0]    vis_waddr, vis_raddr;
  logic [CW-1:0]    vis_wdata, vis_rdata;
  logic             stk_we, stk_re;
  logic [IW-1:0]    stk_waddr, stk_raddr;
  logic [2*IW-1:0]  stk_wdata, stk_rdata;

  logic [IW-1:0] part_lv;
  logic [IW-1:0] stk_lv;
  logic [IW-1:0] stk_cur;

  assign lt_wide  = LW'(left_total);
  assign lt_eff   = (lt_wide > LW'(NODES)) ? LW'(NODES) : lt_wide;
  assign li_wide  = EW'(left_index);
  assign ri_wide  = EW'(right_index);
  assign epoch    = {1'b0, root} + CW'(1);
  assign sp_m1    = sp - CW'(1);
  assign sp_m2    = sp - CW'(2);
  assign part_lv  = part_rdata[IW-1:0];
  assign stk_lv   = stk_rdata[2*IW-1:IW];
  assign stk_cur  = stk_rdata[IW-1:0];
  assign cnt_wide = MW'(count);
  assign nt_wide  = MW'(nt_q);
  assign ind_diff = nt_wide - cnt_wide;

  assign stat.item_cmd   = cmd_q;
  assign stat.edge_ok    = edge_ok;
  assign stat.sweep_last = (sweep == IW'(NODES - 1));
  assign stat.lt_zero    = (lt_q == '0);
  assign stat.root_last  = ({1'b0, root} == (lt_q - CW'(1)));
  assign stat.next_end   = (top_next == CW'(NODES));
  assign stat.row_bit    = adj_rdata[top_next[IW-1:0]];
  assign stat.unmatched  = !part_rdata[IW];
  assign stat.push_block = (vis_rdata == epoch) || (sp == CW'(NODES));
  assign stat.sp_one     = (sp == CW'(1));

  always_comb begin
    adj_we     = 1'b0;
    adj_waddr  = sweep;
    adj_wdata  = '0;
    adj_re     = 1'b0;
    adj_raddr  = root;
    part_we    = 1'b0;
    part_waddr = sweep;
    part_wdata = '0;
    part_re    = 1'b0;
    part_raddr = top_next[IW-1:0];
    vis_we     = 1'b0;
    vis_waddr  = sweep;
    vis_wdata  = '0;
    vis_re     = 1'b0;
    vis_raddr  = part_lv;
    stk_we     = 1'b0;
    stk_waddr  = sp_m1[IW-1:0];
    stk_wdata  = {top_lv, top_cur};
    stk_re     = 1'b0;
    stk_raddr  = sp_m1[IW-1:0];
    unique case (ctl.op)
      OP_ADJ_CLR: begin
        adj_we = 1'b1;
      end
      OP_EDGE_RD: begin
        adj_re    = 1'b1;
        adj_raddr = li_q;
      end
      OP_EDGE_WR: begin
        adj_we    = 1'b1;
        adj_waddr = li_q;
        adj_wdata = adj_rdata | (NODES'(1) << ri_q);
      end
      OP_PART_CLR: begin
        part_we = 1'b1;
        vis_we  = 1'b1;
      end
      OP_ROOT_START: begin
        vis_we    = 1'b1;
        vis_waddr = root;
        vis_wdata = epoch;
        adj_re    = 1'b1;
        adj_raddr = root;
      end
      OP_FOUND: begin
        part_re = 1'b1;
      end
      OP_VIS_RD: begin
        vis_re = 1'b1;
      end
      OP_PUSH: begin
        stk_we    = 1'b1;
        vis_we    = 1'b1;
        vis_waddr = part_lv;
        vis_wdata = epoch;
        adj_re    = 1'b1;
        adj_raddr = part_lv;
      end
      OP_POP_RD: begin
        stk_re    = 1'b1;
        stk_raddr = sp_m2[IW-1:0];
      end
      OP_POP_LOAD: begin
        adj_re    = 1'b1;
        adj_raddr = stk_lv;
      end
      OP_AUG_TOP: begin
        part_we    = 1'b1;
        part_waddr = top_cur;
        part_wdata = {1'b1, top_lv};
      end
      OP_AUG_RD: begin
        stk_re = 1'b1;
      end
      OP_AUG_WR: begin
        part_we    = 1'b1;
        part_waddr = stk_cur;
        part_wdata = {1'b1, stk_lv};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ctl.op)
        OP_LOAD: begin
          cmd_q   <= cmd_t'(cmd);
          edge_ok <= (li_wide < EW'(NODES)) && (ri_wide < EW'(NODES));
          li_q    <= li_wide[IW-1:0];
          ri_q    <= ri_wide[IW-1:0];
          lt_q    <= lt_eff[CW-1:0];
          nt_q    <= node_total;
        end
        OP_ADJ_CLR, OP_PART_CLR: begin
          sweep <= (sweep == IW'(NODES - 1)) ? '0 : sweep + IW'(1);
        end
        OP_SOLVE_INIT: begin
          count <= '0;
          root  <= '0;
        end
        OP_ROOT_START: begin
          top_lv   <= root;
          top_next <= '0;
          sp       <= CW'(1);
        end
        OP_SCAN_STEP: begin
          top_next <= top_next + CW'(1);
        end
        OP_FOUND: begin
          top_cur  <= top_next[IW-1:0];
          top_next <= top_next + CW'(1);
        end
        OP_PUSH: begin
          top_lv   <= part_lv;
          top_next <= '0;
          sp       <= sp + CW'(1);
        end
        OP_POP_RD: begin
          sp <= sp_m1;
        end
        OP_POP_LOAD: begin
          top_lv   <= stk_lv;
          top_cur  <= stk_cur;
          top_next <= {1'b0, stk_cur} + CW'(1);
        end
        OP_AUG_TOP: begin
          count <= count + CW'(1);
          sp    <= sp_m1;
        end
        OP_AUG_WR: begin
          sp <= sp_m1;
        end
        OP_ROOT_NEXT: begin
          root <= root + IW'(1);
        end
        OP_REPORT: begin
          done <= 1'b1;
          if (cmd_q == CMD_SOLVE) begin
            solved           <= 1'b1;
            matching_size    <= (cnt_wide > MW'(MATCH_SAT)) ? 7'(MATCH_SAT) : cnt_wide[6:0];
            independent_size <= (nt_wide > cnt_wide) ? ind_diff[7:0] : 8'd0;
          end else begin
            solved           <= 1'b0;
            matching_size    <= 7'd0;
            independent_size <= 8'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  mbm_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  mbm_ram #(.WIDTH(CW), .DEPTH(NODES)) u_part_ram (
    .clk   (clk),
    .we    (part_we),
    .waddr (part_waddr),
    .wdata (part_wdata),
    .re    (part_re),
    .raddr (part_raddr),
    .rdata (part_rdata)
  );

  mbm_ram #(.WIDTH(CW), .DEPTH(NODES)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .re    (vis_re),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  mbm_ram #(.WIDTH(2 * IW), .DEPTH(NODES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

@@ hdl/mbm_ctrl.sv @@
module mbm_ctrl
  import mbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl,
  output logic     busy
);

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_DECODE,
    S_ADJ_CLR,
    S_EDGE_WR,
    S_PART_CLR,
    S_SOLVE_INIT,
    S_ROOT,
    S_SCAN,
    S_P_WAIT,
    S_V_WAIT,
    S_POP_LOAD,
    S_AUG_RD,
    S_AUG_WR,
    S_NEXT_ROOT,
    S_REPORT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl.op     = OP_NOP;
    unique case (state)
      S_INIT_CLR: begin
        ctl.op = OP_ADJ_CLR;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.item_cmd)
          CMD_CLEAR: state_next = S_ADJ_CLR;
          CMD_ADD: begin
            if (stat.edge_ok) begin
              ctl.op     = OP_EDGE_RD;
              state_next = S_EDGE_WR;
            end else begin
              state_next = S_REPORT;
            end
          end
          CMD_SOLVE: state_next = S_PART_CLR;
          default:   state_next = S_REPORT;
        endcase
      end
      S_ADJ_CLR: begin
        ctl.op = OP_ADJ_CLR;
        if (stat.sweep_last) begin
          state_next = S_REPORT;
        end
      end
      S_EDGE_WR: begin
        ctl.op     = OP_EDGE_WR;
        state_next = S_REPORT;
      end
      S_PART_CLR: begin
        ctl.op = OP_PART_CLR;
        if (stat.sweep_last) begin
          state_next = S_SOLVE_INIT;
        end
      end
      S_SOLVE_INIT: begin
        ctl.op     = OP_SOLVE_INIT;
        state_next = stat.lt_zero ? S_REPORT : S_ROOT;
      end
      S_ROOT: begin
        ctl.op     = OP_ROOT_START;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        priority if (stat.next_end) begin
          if (stat.sp_one) begin
            state_next = S_NEXT_ROOT;
          end else begin
            ctl.op     = OP_POP_RD;
            state_next = S_POP_LOAD;
          end
        end else if (stat.row_bit) begin
          ctl.op     = OP_FOUND;
          state_next = S_P_WAIT;
        end else begin
          ctl.op = OP_SCAN_STEP;
        end
      end
      S_P_WAIT: begin
        if (stat.unmatched) begin
          ctl.op     = OP_AUG_TOP;
          state_next = stat.sp_one ? S_NEXT_ROOT : S_AUG_RD;
        end else begin
          ctl.op     = OP_VIS_RD;
          state_next = S_V_WAIT;
        end
      end
      S_V_WAIT: begin
        if (!stat.push_block) begin
          ctl.op = OP_PUSH;
        end
        state_next = S_SCAN;
      end
      S_POP_LOAD: begin
        ctl.op     = OP_POP_LOAD;
        state_next = S_SCAN;
      end
      S_AUG_RD: begin
        ctl.op     = OP_AUG_RD;
        state_next = S_AUG_WR;
      end
      S_AUG_WR: begin
        ctl.op     = OP_AUG_WR;
        state_next = stat.sp_one ? S_NEXT_ROOT : S_AUG_RD;
      end
      S_NEXT_ROOT: begin
        ctl.op     = OP_ROOT_NEXT;
        state_next = stat.root_last ? S_REPORT : S_ROOT;
      end
      S_REPORT: begin
        ctl.op     = OP_REPORT;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT_CLR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

@@ hdl/max_bipartite_matching_top.sv @@
// Channel   Handshake               Fields
// command   start (in), busy (out)  cmd, left_index, right_index, left_total, node_total
// result    done strobe (out)       matching_size, independent_size, solved
//
// A transaction is taken when start is high and busy is low; each gives one result,
// shown for one cycle with done high. Clear sweeps every row of the edge memory, a
// valid add edge reads and rewrites one row, and other codes only report. Solve clears
// the partner and visited memories, then tries each left vertex in turn as the root of
// an augmenting-path search; the row scan, testing adjacency bits one at a time, sets
// the pace of that search.
// After reset, busy stays high while the edge memory is cleared.
// The receiver cannot stall results.
module max_bipartite_matching_top
  import mbm_pkg::*;
#(
  parameter int NODES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [5:0] left_index,
  input  logic [5:0] right_index,
  input  logic [6:0] left_total,
  input  logic [7:0] node_total,
  output logic       done,
  output logic [6:0] matching_size,
  output logic [7:0] independent_size,
  output logic       solved
);

  dp_ctl_t  ctl;
  dp_stat_t stat;
  logic     ctl_start;

  assign ctl_start = start && !busy;

  mbm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (ctl_start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  mbm_datapath #(.NODES(NODES)) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .cmd              (cmd),
    .left_index       (left_index),
    .right_index      (right_index),
    .left_total       (left_total),
    .node_total       (node_total),
    .done             (done),
    .matching_size    (matching_size),
    .independent_size (independent_size),
    .solved           (solved)
  );

endmodule

@@ bench/max_bipartite_matching_top_tb.sv @@
`timescale 1ns / 100ps

module max_bipartite_matching_top_tb
  import mbm_pkg::*;
;

  localparam int NODES = 64;
  localparam int UNMATCHED = NODES;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int ITEM_TARGET = 1050;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [6:0] size;
    logic [7:0] indep;
    logic       solved;
  } answer_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] cmd;
  logic [5:0] left_index;
  logic [5:0] right_index;
  logic [6:0] left_total;
  logic [7:0] node_total;
  logic       done;
  logic [6:0] matching_size;
  logic [7:0] independent_size;
  logic       solved;

  logic [NODES-1:0] adj_rows [NODES];
  int               mate [NODES];
  answer_t          pending_answers [$];
  int               items_sent;
  int               mismatch_count;
  bit               gaps_on;

  max_bipartite_matching_top #(
    .NODES(NODES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .left_index(left_index),
    .right_index(right_index),
    .left_total(left_total),
    .node_total(node_total),
    .done(done),
    .matching_size(matching_size),
    .independent_size(independent_size),
    .solved(solved)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #100_000_000;
    $display("max_bipartite_matching_top_tb: errors");
    $finish;
  end

  function automatic int augment_path(input int root);
    int               stk_lv [NODES];
    int               stk_cur [NODES];
    int               stk_next [NODES];
    logic [NODES-1:0] seen;
    int               sp;
    int               r;
    int               l2;
    int               k;
    seen = '0;
    seen[root] = 1'b1;
    stk_lv[0] = root;
    stk_cur[0] = 0;
    stk_next[0] = 0;
    sp = 1;
    while (sp > 0) begin
      r = stk_next[sp-1];
      while (r < NODES && !adj_rows[stk_lv[sp-1]][r]) r++;
      if (r >= NODES) begin
        sp--;
      end else begin
        stk_cur[sp-1] = r;
        stk_next[sp-1] = r + 1;
        if (mate[r] == UNMATCHED) begin
          for (k = sp; k > 0; k--) mate[stk_cur[k-1]] = stk_lv[k-1];
          return 1;
        end
        l2 = mate[r];
        if (l2 < NODES && !seen[l2] && sp < NODES) begin
          seen[l2] = 1'b1;
          stk_lv[sp] = l2;
          stk_cur[sp] = 0;
          stk_next[sp] = 0;
          sp++;
        end
      end
    end
    return 0;
  endfunction

  function automatic answer_t predict_answer(input logic [1:0] c, input logic [5:0] li,
                                             input logic [5:0] ri, input logic [6:0] lt,
                                             input logic [7:0] nt);
    answer_t a;
    int      roots;
    int      found;
    int      i;
    a = '0;
    case (c)
      CMD_CLEAR: begin
        for (i = 0; i < NODES; i++) adj_rows[i] = '0;
      end
      CMD_ADD: begin
        adj_rows[li][ri] = 1'b1;
      end
      CMD_SOLVE: begin
        roots = (lt > NODES) ? NODES : lt;
        for (i = 0; i < NODES; i++) mate[i] = UNMATCHED;
        found = 0;
        for (i = 0; i < roots; i++) found += augment_path(i);
        a.size = 7'((found > MATCH_SAT) ? MATCH_SAT : found);
        a.indep = (nt > found) ? 8'(nt - found) : 8'd0;
        a.solved = 1'b1;
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_item(input logic [1:0] c, input logic [5:0] li, input logic [5:0] ri,
                           input logic [6:0] lt, input logic [7:0] nt);
    int      gap;
    answer_t predicted;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    left_index <= li;
    right_index <= ri;
    left_total <= lt;
    node_total <= nt;
    do @(posedge clk); while (busy);
    predicted = predict_answer(c, li, ri, lt, nt);
    pending_answers.insert(pending_answers.size(), predicted);
    items_sent++;
  endtask

  task automatic report_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result expected none actual %0d %0d %0d", $time,
                 matching_size, independent_size, solved);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        report_field("matching_size", int'(want.size), int'(matching_size));
        report_field("independent_size", int'(want.indep), int'(independent_size));
        report_field("solved", int'(want.solved), int'(solved));
      end
    end
  end

  task automatic test_empty_graph();
    send_item(CMD_SOLVE, 6'd0, 6'd0, 7'd0, 8'd0);
    send_item(CMD_SOLVE, 6'd63, 6'd63, 7'd64, 8'd255);
  endtask

  task automatic test_corner_edges();
    send_item(CMD_CLEAR, 6'd63, 6'd63, 7'd127, 8'd255);
    send_item(CMD_ADD, 6'd0, 6'd0, 7'd0, 8'd0);
    send_item(CMD_ADD, 6'd63, 6'd63, 7'd127, 8'd255);
    send_item(CMD_ADD, 6'd0, 6'd63, 7'd0, 8'd0);
    send_item(CMD_ADD, 6'd63, 6'd0, 7'd0, 8'd0);
    send_item(CMD_SOLVE, 6'd0, 6'd0, 7'd64, 8'd128);
    send_item(CMD_SOLVE, 6'd0, 6'd0, 7'd127, 8'd255);
    send_item(CMD_SOLVE, 6'd0, 6'd0, 7'd64, 8'd1);
    send_item(CMD_SOLVE, 6'd0, 6'd0, 7'd0, 8'd7);
  endtask

  task automatic test_augmenting_chain();
    send_item(CMD_CLEAR, 6'd0, 6'd0, 7'd0, 8'd0);
    send_item(CMD_ADD, 6'd0, 6'd0, 7'd0, 8'd0);
    send_item(CMD_ADD, 6'd0, 6'd1, 7'd0, 8'd0);
    send_item(CMD_ADD, 6'd1, 6'd0, 7'd0, 8'd0);
    send_item(CMD_ADD, 6'd2, 6'd1, 7'd0, 8'd0);
    send_item(CMD_ADD, 6'd2, 6'd2, 7'd0, 8'd0);
    send_item(CMD_SOLVE, 6'd0, 6'd0, 7'd3, 8'd6);
  endtask

  task automatic test_clear_and_unknown();
    send_item(CMD_UNKNOWN, 6'd63, 6'd63, 7'd127, 8'd255);
    send_item(CMD_SOLVE, 6'd0, 6'd0, 7'd3, 8'd2);
    send_item(CMD_CLEAR, 6'd0, 6'd0, 7'd0, 8'd0);
    send_item(CMD_SOLVE, 6'd0, 6'd0, 7'd64, 8'd64);
  endtask

  task automatic test_random_graphs();
    int n;
    int edges;
    int j;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, NODES) : $urandom_range(1, 12);
      if ($urandom_range(0, 7) != 0)
        send_item(CMD_CLEAR, 6'($urandom), 6'($urandom), 7'($urandom), 8'($urandom));
      edges = $urandom_range(0, 3 * n);
      for (j = 0; j < edges; j++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(CMD_UNKNOWN, 6'($urandom), 6'($urandom), 7'($urandom), 8'($urandom));
        else if ($urandom_range(0, 29) == 0)
          send_item(CMD_ADD, 6'($urandom), 6'($urandom), 7'($urandom), 8'($urandom));
        else
          send_item(CMD_ADD, 6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)),
                    7'($urandom), 8'($urandom));
      end
      send_item(CMD_SOLVE, 6'($urandom), 6'($urandom),
                ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) : 7'(n),
                8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_CLEAR;
    left_index = '0;
    right_index = '0;
    left_total = '0;
    node_total = '0;
    items_sent = 0;
    mismatch_count = 0;
    gaps_on = 1'b1;
    for (int i = 0; i < NODES; i++) begin
      adj_rows[i] = '0;
      mate[i] = UNMATCHED;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_graph();
    test_corner_edges();
    test_augmenting_chain();
    gaps_on = 1'b0;
    test_clear_and_unknown();
    test_random_graphs();

    @(negedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("max_bipartite_matching_top_tb: clean");
    end else begin
      $display("max_bipartite_matching_top_tb: errors");
    end
    $finish;
  end

endmodule
